[sv/wfd_pkg.sv]
// ----------------------------------------------------------------------------
// wfd_pkg
// Types and constants shared by the wrapper frame deframer modules.
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65544;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_SIZE   = 2'd2;

  localparam logic [WORD_W-1:0]  RST_EXPECTED_VERSION = 16'd1;
  localparam logic [WORD_W-1:0]  RST_MAX_DATA_SIZE    = 16'd65535;
  localparam logic [COUNT_W-1:0] RST_MAX_FRAME_SIZE   = 17'd65543;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NEED_MORE = 3'd1;
  localparam logic [2:0] ST_VERSION   = 3'd2;
  localparam logic [2:0] ST_DATA_BIG  = 3'd3;
  localparam logic [2:0] ST_FRAME_BIG = 3'd4;
  localparam logic [2:0] ST_LENGTH    = 3'd5;
  localparam logic [2:0] ST_SRC       = 3'd6;
  localparam logic [2:0] ST_DST       = 3'd7;

  typedef struct packed {
    logic              has_payload;
    logic [7:0]        payload_byte;
    logic              has_status;
    logic [2:0]        status_code;
    logic [WORD_W-1:0] source_port;
    logic [WORD_W-1:0] destination_port;
    logic [WORD_W-1:0] data_length;
  } wfd_cmd_t;

  typedef struct packed {
    logic              item_kind;
    logic [7:0]        payload_byte;
    logic [2:0]        status_code;
    logic [WORD_W-1:0] source_port;
    logic [WORD_W-1:0] destination_port;
    logic [WORD_W-1:0] data_length;
    logic              end_of_run;
  } wfd_result_t;

endpackage

[sv/wfd_ifs.sv]
// ----------------------------------------------------------------------------
// wfd channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface wfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface wfd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status_code;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] data_length;
  logic        end_of_run;
  modport source (output valid, output item_kind, output payload_byte,
                  output status_code, output source_port, output destination_port,
                  output data_length, output end_of_run, input ready);
  modport sink (input valid, input item_kind, input payload_byte,
                input status_code, input source_port, input destination_port,
                input data_length, input end_of_run, output ready);
endinterface

interface wfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/wfd_front.sv]
// ----------------------------------------------------------------------------
// wfd_front
// Accepts frame bytes, gathers the header, classifies each byte and pushes
// a command (payload byte and/or end-of-frame status) into the queue.
// ----------------------------------------------------------------------------
module wfd_front (
  input  logic             clk,
  input  logic             rst_n,
  wfd_in_if.sink           in_ch,
  wfd_cfg_if.sink          cfg_ch,
  input  logic             q_ready,
  output logic             q_push,
  output wfd_pkg::wfd_cmd_t q_cmd
);

  logic [wfd_pkg::WORD_W-1:0]  exp_ver_r;
  logic [wfd_pkg::WORD_W-1:0]  max_data_r;
  logic [wfd_pkg::COUNT_W-1:0] max_frame_r;

  logic [wfd_pkg::COUNT_W-1:0] cnt_r, cnt_inc;
  logic [wfd_pkg::WORD_W-1:0]  ver_r, src_r, dst_r, len_r;
  logic [wfd_pkg::WORD_W-1:0]  ver_nxt, src_nxt, dst_nxt, len_nxt;
  logic [wfd_pkg::COUNT_W-1:0] len_end_r, len_end_nxt;
  logic                        acc, in_hdr, is_pay;
  logic [2:0]                  code;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = q_ready;
  assign acc          = in_ch.valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r   <= wfd_pkg::RST_EXPECTED_VERSION;
      max_data_r  <= wfd_pkg::RST_MAX_DATA_SIZE;
      max_frame_r <= wfd_pkg::RST_MAX_FRAME_SIZE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        wfd_pkg::CFG_EXPECTED_VERSION: exp_ver_r <= cfg_ch.data[wfd_pkg::WORD_W-1:0];
        wfd_pkg::CFG_MAX_DATA_SIZE:    max_data_r <= cfg_ch.data[wfd_pkg::WORD_W-1:0];
        wfd_pkg::CFG_MAX_FRAME_SIZE:   max_frame_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_hdr    = (cnt_r < wfd_pkg::HDR_BYTES);
  assign len_end_r = {1'b0, len_r} + wfd_pkg::HDR_BYTES;
  assign is_pay    = !in_hdr && (cnt_r < len_end_r);
  assign cnt_inc   = (cnt_r == wfd_pkg::COUNT_MAX) ? cnt_r : cnt_r + 17'd1;

  always_comb begin
    ver_nxt = ver_r;
    src_nxt = src_r;
    dst_nxt = dst_r;
    len_nxt = len_r;
    if (in_hdr) begin
      case (cnt_r[2:1])
        2'd0:    ver_nxt = {ver_r[7:0], in_ch.data_byte};
        2'd1:    src_nxt = {src_r[7:0], in_ch.data_byte};
        2'd2:    dst_nxt = {dst_r[7:0], in_ch.data_byte};
        default: len_nxt = {len_r[7:0], in_ch.data_byte};
      endcase
    end
  end

  assign len_end_nxt = {1'b0, len_nxt} + wfd_pkg::HDR_BYTES;

  always_comb begin
    if (cnt_inc < wfd_pkg::HDR_BYTES) code = wfd_pkg::ST_NEED_MORE;
    else if (ver_nxt != exp_ver_r) code = wfd_pkg::ST_VERSION;
    else if (len_nxt > max_data_r) code = wfd_pkg::ST_DATA_BIG;
    else if (len_end_nxt > max_frame_r) code = wfd_pkg::ST_FRAME_BIG;
    else if (cnt_inc < len_end_nxt) code = wfd_pkg::ST_NEED_MORE;
    else if (cnt_inc > len_end_nxt) code = wfd_pkg::ST_LENGTH;
    else if (src_nxt == '0) code = wfd_pkg::ST_SRC;
    else if (dst_nxt == '0) code = wfd_pkg::ST_DST;
    else code = wfd_pkg::ST_OK;
  end

  always_comb begin
    q_cmd.has_payload      = is_pay;
    q_cmd.payload_byte     = in_ch.data_byte;
    q_cmd.has_status       = in_ch.final_byte;
    q_cmd.status_code      = code;
    q_cmd.source_port      = (code == wfd_pkg::ST_OK) ? src_nxt : '0;
    q_cmd.destination_port = (code == wfd_pkg::ST_OK) ? dst_nxt : '0;
    q_cmd.data_length      = (code == wfd_pkg::ST_OK) ? len_nxt : '0;
  end

  assign q_push = acc && (is_pay || in_ch.final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ver_r <= '0;
      src_r <= '0;
      dst_r <= '0;
      len_r <= '0;
    end else if (acc) begin
      if (in_ch.final_byte) begin
        cnt_r <= '0;
        ver_r <= '0;
        src_r <= '0;
        dst_r <= '0;
        len_r <= '0;
      end else begin
        cnt_r <= cnt_inc;
        ver_r <= ver_nxt;
        src_r <= src_nxt;
        dst_r <= dst_nxt;
        len_r <= len_nxt;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wfd_pkg::COUNT_MAX)
    else $error("byte count beyond saturation value");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.final_byte) |=> (cnt_r == '0 && len_r == '0))
    else $error("frame state not cleared after final byte");

endmodule

[sv/wfd_queue.sv]
// ----------------------------------------------------------------------------
// wfd_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module wfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wfd_pkg::wfd_cmd_t push_cmd,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output wfd_pkg::wfd_cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wfd_pkg::wfd_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign not_full  = (cnt_r != CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[sv/wfd_back.sv]
// ----------------------------------------------------------------------------
// wfd_back
// Expands queued commands into result items: the payload byte first, then
// the end-of-frame status, through a registered output stage.
// ----------------------------------------------------------------------------
module wfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  wfd_pkg::wfd_cmd_t q_head,
  output logic              q_pop,
  wfd_out_if.source         out_ch
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 pend_r, pend_nxt;
  wfd_pkg::wfd_result_t out_item_r, out_item_nxt;
  wfd_pkg::wfd_result_t pend_item_r, pend_item_nxt;
  wfd_pkg::wfd_result_t pay_item, stat_item;
  logic                 slot_free;

  always_comb begin
    pay_item                  = '0;
    pay_item.item_kind        = wfd_pkg::KIND_PAYLOAD;
    pay_item.payload_byte     = q_head.payload_byte;
    stat_item                  = '0;
    stat_item.item_kind        = wfd_pkg::KIND_STATUS;
    stat_item.status_code      = q_head.status_code;
    stat_item.source_port      = q_head.source_port;
    stat_item.destination_port = q_head.destination_port;
    stat_item.data_length      = q_head.data_length;
    stat_item.end_of_run       = 1'b1;
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    pend_nxt      = pend_r;
    pend_item_nxt = pend_item_r;
    q_pop         = 1'b0;
    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = pend_item_r;
        pend_nxt      = 1'b0;
      end else if (q_not_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        if (q_head.has_payload) begin
          out_item_nxt  = pay_item;
          pend_nxt      = q_head.has_status;
          pend_item_nxt = stat_item;
        end else begin
          out_item_nxt = stat_item;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    pend_item_r <= pend_item_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.item_kind        = out_item_r.item_kind;
  assign out_ch.payload_byte     = out_item_r.payload_byte;
  assign out_ch.status_code      = out_item_r.status_code;
  assign out_ch.source_port      = out_item_r.source_port;
  assign out_ch.destination_port = out_item_r.destination_port;
  assign out_ch.data_length      = out_item_r.data_length;
  assign out_ch.end_of_run       = out_item_r.end_of_run;

  a_pend_behind_payload: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && out_item_r.item_kind == wfd_pkg::KIND_PAYLOAD))
    else $error("pending status without a payload item ahead of it");

  a_no_pop_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && slot_free) |-> !q_pop)
    else $error("queue popped while a status item was still pending");

endmodule

[sv/wrapper_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// wrapper_frame_deframer_top
// Wrapper frame deframer: header gathering, payload pass-through and
// end-of-frame status checking.
// ----------------------------------------------------------------------------
//  Channel   Role        Carries
//  in_ch     sink        data_byte, final_byte
//  out_ch    source      item_kind, payload_byte, status_code, ports, length,
//                        end_of_run
//  cfg_ch    sink        index, data (expected version, max data, max frame)
//
// One byte is accepted per cycle while the queue is not full; the status for
// a frame leaves after its last payload byte, so a final payload byte needs
// two output items and the command queue absorbs the extra item.
// A result is offered at the earliest once its command has passed the queue
// slot and the output register.
// Reset is synchronous; no clearing pass is needed.
// Output stalls fill the queue, and input ready drops only when it is full.
// ----------------------------------------------------------------------------
module wrapper_frame_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  wfd_in_if.sink     in_ch,
  wfd_out_if.source  out_ch,
  wfd_cfg_if.sink    cfg_ch
);

  logic              q_push, q_not_full, q_pop, q_not_empty;
  wfd_pkg::wfd_cmd_t q_cmd, q_head;

  wfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_ready (q_not_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  wfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  wfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
